FILE: hw/rtl/raa_pkg.sv
// Shared constants and types for the reconfigurable approximate adder.
package raa_pkg;

   localparam int DEFAULT_WIDTH = 16;
   localparam int CFG_BITS = 4;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_RESULT_BITS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PREDICT_BITS = 1'b1;

   localparam logic [CFG_BITS-1:0] RESET_RESULT_BITS = 4'd4;
   localparam logic [CFG_BITS-1:0] RESET_PREDICT_BITS = 4'd4;

   typedef struct packed {
      logic [CFG_BITS-1:0] result_len;
      logic [CFG_BITS-1:0] predict_len;
   } cfg_type;

endpackage

FILE: hw/rtl/raa_csr.sv
// Configuration registers and the sequencer that builds the predicted-carry position mask.
module raa_csr #(
   parameter int WIDTH = raa_pkg::DEFAULT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [raa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [raa_pkg::CFG_BITS-1:0]        csr_wdata,
   output raa_pkg::cfg_type                    cfg,
   output logic [WIDTH-1:0]                    predict_mask,
   output logic                                building
);

   localparam int POS_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int EXACT_BITS = raa_pkg::CFG_BITS + 1;
   localparam int CMP_BITS = (POS_BITS > EXACT_BITS) ? POS_BITS : EXACT_BITS;
   localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(WIDTH - 1);

   logic [raa_pkg::CFG_BITS-1:0] result_bits_ff, result_bits_in;
   logic [raa_pkg::CFG_BITS-1:0] predict_bits_ff, predict_bits_in;
   logic                         build_ff, build_in;
   logic [POS_BITS-1:0]          pos_ff, pos_in;
   logic [raa_pkg::CFG_BITS-1:0] phase_ff, phase_in;
   logic [WIDTH-1:0]             mask_ff, mask_in;

   logic [raa_pkg::CFG_BITS-1:0] r_eff, p_eff;
   logic [EXACT_BITS-1:0]        exact_end;
   logic                         past_exact, hit;

   always_comb begin
      r_eff = (result_bits_ff == '0) ? raa_pkg::CFG_BITS'(1) : result_bits_ff;
      p_eff = (predict_bits_ff == '0) ? raa_pkg::CFG_BITS'(1) : predict_bits_ff;
      exact_end = EXACT_BITS'(r_eff) + EXACT_BITS'(p_eff) - EXACT_BITS'(1);
      past_exact = CMP_BITS'(pos_ff) >= CMP_BITS'(exact_end);
      hit = past_exact && (phase_ff == '0) && (pos_ff != LAST_POS);

      result_bits_in = result_bits_ff;
      predict_bits_in = predict_bits_ff;
      build_in = build_ff;
      pos_in = pos_ff;
      phase_in = phase_ff;
      mask_in = mask_ff;

      if (csr_write_enable) begin
         case (csr_index)
            raa_pkg::REG_RESULT_BITS: begin
               result_bits_in = csr_wdata;
            end
            raa_pkg::REG_PREDICT_BITS: begin
               predict_bits_in = csr_wdata;
            end
            default: begin
            end
         endcase
         build_in = 1'b1;
         pos_in = '0;
         phase_in = '0;
      end else if (build_ff) begin
         mask_in[pos_ff] = hit;
         if (past_exact) begin
            phase_in = (phase_ff == r_eff - raa_pkg::CFG_BITS'(1)) ? '0
                                                                  : phase_ff + 1'b1;
         end
         pos_in = pos_ff + 1'b1;
         if (pos_ff == LAST_POS) begin
            build_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_bits_ff <= raa_pkg::RESET_RESULT_BITS;
         predict_bits_ff <= raa_pkg::RESET_PREDICT_BITS;
         build_ff <= 1'b1;
         pos_ff <= '0;
         phase_ff <= '0;
      end else begin
         result_bits_ff <= result_bits_in;
         predict_bits_ff <= predict_bits_in;
         build_ff <= build_in;
         pos_ff <= pos_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
   end

   assign cfg.result_len = r_eff;
   assign cfg.predict_len = p_eff;
   assign predict_mask = mask_ff;
   assign building = build_ff;

   a_write_rebuilds: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> build_ff)
      else $error("mask rebuild not started after register write");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      build_ff |-> (phase_ff < cfg.result_len))
      else $error("spacing counter out of range");

   a_top_not_predicted: assert property (@(posedge clock) disable iff (reset)
      !build_ff |-> !mask_ff[WIDTH-1])
      else $error("top position marked as predicted");

endmodule

FILE: hw/rtl/raa_blocks.sv
// Stages 1-2: bit generate/propagate and group terms of length 2, 4 and 8 ending at each bit.
module raa_blocks #(
   parameter int WIDTH = raa_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] addend_a,
   input  logic [WIDTH-1:0] addend_b,
   output logic             out_valid,
   output logic [WIDTH-1:0] gen1,
   output logic [WIDTH-1:0] prop1,
   output logic [WIDTH-1:0] gen2,
   output logic [WIDTH-1:0] prop2,
   output logic [WIDTH-1:0] gen4,
   output logic [WIDTH-1:0] prop4,
   output logic [WIDTH-1:0] gen8,
   output logic [WIDTH-1:0] prop8
);

   logic             s1_valid_ff;
   logic [WIDTH-1:0] s1_gen_ff, s1_prop_ff;

   logic             s2_valid_ff;
   logic [WIDTH-1:0] s2_gen1_ff, s2_prop1_ff;
   logic [WIDTH-1:0] s2_gen2_ff, s2_prop2_ff;
   logic [WIDTH-1:0] s2_gen4_ff, s2_prop4_ff;
   logic [WIDTH-1:0] s2_gen8_ff, s2_prop8_ff;

   logic [WIDTH-1:0] gen2_in, prop2_in, gen4_in, prop4_in, gen8_in, prop8_in;

   // groups reaching below bit 0 see zero bits there
   always_comb begin
      gen2_in = s1_gen_ff | (s1_prop_ff & (s1_gen_ff << 1));
      prop2_in = s1_prop_ff & (s1_prop_ff << 1);
      gen4_in = gen2_in | (prop2_in & (gen2_in << 2));
      prop4_in = prop2_in & (prop2_in << 2);
      gen8_in = gen4_in | (prop4_in & (gen4_in << 4));
      prop8_in = prop4_in & (prop4_in << 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_gen_ff <= addend_a & addend_b;
      s1_prop_ff <= addend_a ^ addend_b;
      s2_gen1_ff <= s1_gen_ff;
      s2_prop1_ff <= s1_prop_ff;
      s2_gen2_ff <= gen2_in;
      s2_prop2_ff <= prop2_in;
      s2_gen4_ff <= gen4_in;
      s2_prop4_ff <= prop4_in;
      s2_gen8_ff <= gen8_in;
      s2_prop8_ff <= prop8_in;
   end

   assign out_valid = s2_valid_ff;
   assign gen1 = s2_gen1_ff;
   assign prop1 = s2_prop1_ff;
   assign gen2 = s2_gen2_ff;
   assign prop2 = s2_prop2_ff;
   assign gen4 = s2_gen4_ff;
   assign prop4 = s2_prop4_ff;
   assign gen8 = s2_gen8_ff;
   assign prop8 = s2_prop8_ff;

endmodule

FILE: hw/rtl/raa_window.sv
// Stage 3: predicted carry over the P-bit window at each bit, merged into the carry terms.
module raa_window #(
   parameter int WIDTH = raa_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  raa_pkg::cfg_type cfg,
   input  logic [WIDTH-1:0] predict_mask,
   input  logic [WIDTH-1:0] gen1,
   input  logic [WIDTH-1:0] prop1,
   input  logic [WIDTH-1:0] gen2,
   input  logic [WIDTH-1:0] prop2,
   input  logic [WIDTH-1:0] gen4,
   input  logic [WIDTH-1:0] prop4,
   input  logic [WIDTH-1:0] gen8,
   input  logic [WIDTH-1:0] prop8,
   output logic             out_valid,
   output logic [WIDTH-1:0] carry_gen,
   output logic [WIDTH-1:0] carry_prop,
   output logic [WIDTH-1:0] bit_prop
);

   logic [raa_pkg::CFG_BITS-1:0] plen;
   logic [WIDTH-1:0] acc_g0, acc_p0, acc_g1, acc_p1, acc_g2, acc_p2, acc_g3;
   logic [WIDTH-1:0] piece2_g, piece2_p, piece4_g, piece4_p, piece8_g;
   logic [WIDTH-1:0] cgen_in, cprop_in;

   logic             s3_valid_ff;
   logic [WIDTH-1:0] s3_cgen_ff, s3_cprop_ff, s3_prop_ff;

   // window split into pieces of 1, 2, 4, 8 bits, top piece first
   always_comb begin
      plen = cfg.predict_len;
      piece2_g = gen2 << plen[0];
      piece2_p = prop2 << plen[0];
      piece4_g = gen4 << plen[1:0];
      piece4_p = prop4 << plen[1:0];
      piece8_g = gen8 << plen[2:0];

      acc_g0 = plen[0] ? gen1 : '0;
      acc_p0 = plen[0] ? prop1 : '1;
      acc_g1 = plen[1] ? (acc_g0 | (acc_p0 & piece2_g)) : acc_g0;
      acc_p1 = plen[1] ? (acc_p0 & piece2_p) : acc_p0;
      acc_g2 = plen[2] ? (acc_g1 | (acc_p1 & piece4_g)) : acc_g1;
      acc_p2 = plen[2] ? (acc_p1 & piece4_p) : acc_p1;
      acc_g3 = plen[3] ? (acc_g2 | (acc_p2 & piece8_g)) : acc_g2;

      cgen_in = (predict_mask & acc_g3) | (~predict_mask & gen1);
      cprop_in = ~predict_mask & prop1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_cgen_ff <= cgen_in;
      s3_cprop_ff <= cprop_in;
      s3_prop_ff <= prop1;
   end

   assign out_valid = s3_valid_ff;
   assign carry_gen = s3_cgen_ff;
   assign carry_prop = s3_cprop_ff;
   assign bit_prop = s3_prop_ff;

endmodule

FILE: hw/rtl/raa_sum.sv
// Stage 4: carry chain with predicted carries injected, sum bits and output register.
module raa_sum #(
   parameter int WIDTH = raa_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] carry_gen,
   input  logic [WIDTH-1:0] carry_prop,
   input  logic [WIDTH-1:0] bit_prop,
   output logic             out_valid,
   output logic [WIDTH:0]   approx_sum
);

   logic [WIDTH:0]   chain;
   logic [WIDTH-1:0] carry_below;
   logic [WIDTH:0]   sum_in;

   logic             rsp_valid_ff;
   logic [WIDTH:0]   rsp_sum_ff;

   // operands chosen so that x&y = generate and x^y = propagate
   always_comb begin
      chain = {1'b0, carry_gen | carry_prop} + {1'b0, carry_gen};
      carry_below = chain[WIDTH-1:0] ^ carry_prop;
      sum_in = {chain[WIDTH], bit_prop ^ carry_below};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= sum_in;
   end

   assign out_valid = rsp_valid_ff;
   assign approx_sum = rsp_sum_ff;

endmodule

FILE: hw/rtl/reconfigurable_approximate_adder.sv
// Top level of the GeAr-style reconfigurable approximate adder.
//
//   channel   ports                                        handshake
//   request   start, busy, req_addend_a, req_addend_b      start && !busy
//   result    rsp_valid, rsp_approx_sum                    one-cycle strobe
//   config    csr_write_enable, csr_index, csr_wdata       write enable
//
// One request per cycle while busy is low; each taken request passes in turn through
// the four register stages (bit terms, group terms, window carry, carry chain).
// After reset and after every register write the predicted-carry mask is rebuilt,
// one bit position per cycle: busy stays high until the top bit position is done.
// Results cannot be held off; nothing in the pipeline stalls.
module reconfigurable_approximate_adder #(
   parameter int WIDTH = raa_pkg::DEFAULT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [WIDTH-1:0]                    req_addend_a,
   input  logic [WIDTH-1:0]                    req_addend_b,
   output logic                                rsp_valid,
   output logic [WIDTH:0]                      rsp_approx_sum,
   input  logic                                csr_write_enable,
   input  logic [raa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [raa_pkg::CFG_BITS-1:0]        csr_wdata
);

   raa_pkg::cfg_type cfg;
   logic [WIDTH-1:0] predict_mask;
   logic             building;
   logic             accept;

   logic             blk_valid;
   logic [WIDTH-1:0] gen1, prop1, gen2, prop2, gen4, prop4, gen8, prop8;

   logic             win_valid;
   logic [WIDTH-1:0] carry_gen, carry_prop, bit_prop;

   assign busy = building;
   assign accept = start && !building;

   raa_csr #(.WIDTH(WIDTH)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg),
      .predict_mask     (predict_mask),
      .building         (building)
   );

   raa_blocks #(.WIDTH(WIDTH)) u_blocks (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .addend_a  (req_addend_a),
      .addend_b  (req_addend_b),
      .out_valid (blk_valid),
      .gen1      (gen1),
      .prop1     (prop1),
      .gen2      (gen2),
      .prop2     (prop2),
      .gen4      (gen4),
      .prop4     (prop4),
      .gen8      (gen8),
      .prop8     (prop8)
   );

   raa_window #(.WIDTH(WIDTH)) u_window (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (blk_valid),
      .cfg          (cfg),
      .predict_mask (predict_mask),
      .gen1         (gen1),
      .prop1        (prop1),
      .gen2         (gen2),
      .prop2        (prop2),
      .gen4         (gen4),
      .prop4        (prop4),
      .gen8         (gen8),
      .prop8        (prop8),
      .out_valid    (win_valid),
      .carry_gen    (carry_gen),
      .carry_prop   (carry_prop),
      .bit_prop     (bit_prop)
   );

   raa_sum #(.WIDTH(WIDTH)) u_sum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .carry_gen  (carry_gen),
      .carry_prop (carry_prop),
      .bit_prop   (bit_prop),
      .out_valid  (rsp_valid),
      .approx_sum (rsp_approx_sum)
   );

   a_request_to_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("request did not produce a result after four cycles");

   a_reset_flushes: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule
